// ===== rtl/core/afpq_pkg.sv =====
package afpq_pkg;

  localparam int QUEUE_FRAMES    = 65;
  localparam int MAX_FRAME_BYTES = 1920;

  localparam int FRAME_MAX_EVEN  = (MAX_FRAME_BYTES / 2) * 2;
  localparam int WORDS_PER_SLOT  = MAX_FRAME_BYTES / 2;
  localparam int RAM_WORDS       = QUEUE_FRAMES * WORDS_PER_SLOT;
  localparam int ADDR_W          = $clog2(RAM_WORDS);
  localparam int SLOT_W          = $clog2(QUEUE_FRAMES);
  localparam int COUNT_W         = 7;
  localparam int OFF_W           = 11;
  localparam int LIMIT_W         = 7;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 11;
  localparam int IN_TDATA_W      = 8;
  localparam int IN_TUSER_W      = 3;
  localparam int OUT_TDATA_W     = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_BYTES    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REALTIME_MODE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT_REALTIME = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT_DEFAULT  = 2'd3;

  localparam logic [OFF_W-1:0]   FRAME_BYTES_RST = 11'd320;
  localparam logic [LIMIT_W-1:0] LIMIT_RST       = 7'd64;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_CKPT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RETRY,
    S_ACT,
    S_READ
  } state_t;

  typedef struct packed {
    logic latch;
    logic retry;
    logic act;
    logic rd_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic               ok;
    logic               drop;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  head;
    logic [SLOT_W-1:0]  tail;
    logic [OFF_W-1:0]   rdoff;
  } commit_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(QUEUE_FRAMES - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [OFF_W-1:0] eff_frame(input logic [OFF_W-1:0] f);
    logic [OFF_W-1:0] v;
    v = f;
    if (v < OFF_W'(2)) begin
      v = OFF_W'(2);
    end
    if (v > OFF_W'(FRAME_MAX_EVEN)) begin
      v = OFF_W'(FRAME_MAX_EVEN);
    end
    eff_frame = {v[OFF_W-1:1], 1'b0};
  endfunction

  function automatic logic [LIMIT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] l);
    logic [LIMIT_W-1:0] v;
    v = l;
    if (v < LIMIT_W'(1)) begin
      v = LIMIT_W'(1);
    end
    if (v > LIMIT_W'(QUEUE_FRAMES - 1)) begin
      v = LIMIT_W'(QUEUE_FRAMES - 1);
    end
    eff_limit = v;
  endfunction

  function automatic commit_t try_commit(
    input logic               rt,
    input logic [LIMIT_W-1:0] lim_rt,
    input logic [LIMIT_W-1:0] lim_def,
    input logic [COUNT_W-1:0] count,
    input logic [SLOT_W-1:0]  head,
    input logic [SLOT_W-1:0]  tail,
    input logic [OFF_W-1:0]   rdoff
  );
    commit_t          c;
    logic [COUNT_W-1:0] cnt;
    cnt     = count;
    c.head  = head;
    c.rdoff = rdoff;
    c.drop  = rt && (count >= COUNT_W'(eff_limit(lim_rt))) && (count != '0);
    c.ok    = rt || (count < COUNT_W'(eff_limit(lim_def)));
    if (c.drop) begin
      c.head  = slot_inc(head);
      c.rdoff = '0;
      cnt     = count - 1'b1;
    end
    c.count = cnt + 1'b1;
    c.tail  = slot_inc(tail);
    try_commit = c;
  endfunction

endpackage

// ===== rtl/core/audio_frame_packer_queue_core.sv =====
// Channel  | Ports            | Beat contents
// in       | in_t*            | tdata: data_byte; tlast: chunk_end;
//          |                  | tuser: action[1:0], has_stream_id[2]
// out      | out_t*           | tdata: out_byte, played_stream, dropped_oldest,
//          |                  | overflow, frames_queued; tlast: frame_last;
//          |                  | tuser: byte_valid
// cfg      | cfg_we/addr/wdata| frame_bytes, realtime_mode, limit_realtime,
//          |                  | limit_default by index
//
// Each beat passes through the controller as accept, held-frame retry and
// execute; a pop adds a final step, the registered frame RAM read.
// Reset is synchronous and clears all control state; the frame RAM has no
// clearing pass and holds 16-bit sample words.
// A result waiting on out_tready does not block acceptance; execute stalls
// until the output register is free.
module audio_frame_packer_queue_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [afpq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [afpq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [afpq_pkg::IN_TDATA_W-1:0]     in_tdata,   // data_byte[7:0]
  input  logic                                in_tlast,
  input  logic [afpq_pkg::IN_TUSER_W-1:0]     in_tuser,   // action[1:0], has_stream_id[2]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_byte[7:0], played_stream[8], dropped_oldest[9], overflow[10], frames_queued[17:11]
  output logic [afpq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser   // byte_valid[0]
);
  import afpq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  afpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  afpq_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .status     (status)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a beat is in flight");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:11] <= 7'(QUEUE_FRAMES - 1))
    else $error("frames_queued above queue limit");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0 && !out_tlast)
    else $error("byte fields set without a popped byte");

  a_played_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tlast && out_tdata[17:11] == 7'd0)
    else $error("played reported without draining the queue");

endmodule

// ===== rtl/core/afpq_ctrl.sv =====
module afpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  afpq_pkg::dp_status_t status,
  output afpq_pkg::ctrl_cmd_t  cmd
);
  import afpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_RETRY;
        end
      end
      S_RETRY: begin
        cmd.retry = 1'b1;
        state_nxt = S_ACT;
      end
      S_ACT: begin
        if (status.out_free) begin
          cmd.act   = 1'b1;
          state_nxt = status.is_pop ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_done = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/afpq_dpath.sv =====
module afpq_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [afpq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [afpq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [afpq_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  input  logic [afpq_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [afpq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser,
  input  afpq_pkg::ctrl_cmd_t                 cmd,
  output afpq_pkg::dp_status_t                status
);
  import afpq_pkg::*;

  logic [OFF_W-1:0]   frame_bytes_r;
  logic               realtime_r;
  logic [LIMIT_W-1:0] lim_rt_r, lim_def_r;

  action_t            act_r;
  logic [7:0]         data_r;
  logic               last_r, has_id_r;

  logic [SLOT_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [OFF_W-1:0]   fill_r, fill_nxt, rdoff_r, rdoff_nxt;
  logic [7:0]         odd_byte_r, odd_byte_nxt;
  logic               odd_valid_r, odd_valid_nxt, held_r, held_nxt;
  logic               ckpt_r, ckpt_nxt, idp_r, idp_nxt;
  logic               drop_acc_r, drop_acc_nxt;

  logic               o_valid_r, o_valid_nxt;
  logic [7:0]         o_byte_r, o_byte_nxt;
  logic               o_bv_r, o_bv_nxt, o_last_r, o_last_nxt;
  logic               o_played_r, o_played_nxt, o_drop_r, o_drop_nxt;
  logic               o_ovf_r, o_ovf_nxt;
  logic [COUNT_W-1:0] o_count_r, o_count_nxt;

  logic [15:0]        ram [RAM_WORDS];
  logic [15:0]        rd_data_r;
  logic               bsel_r, bsel_nxt;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_wa, ram_ra;
  logic [15:0]        ram_wd;

  commit_t            cm;
  logic [OFF_W-1:0]   eff_f, fill_add, off_cl, rdoff_inc;
  logic [COUNT_W-1:0] count_dec;

  assign eff_f = eff_frame(frame_bytes_r);
  assign cm    = try_commit(realtime_r, lim_rt_r, lim_def_r, count_r, head_r, tail_r,
                            rdoff_r);

  assign fill_add  = fill_r + OFF_W'(2);
  assign off_cl    = (rdoff_r >= OFF_W'(MAX_FRAME_BYTES)) ? OFF_W'(MAX_FRAME_BYTES - 1)
                                                         : rdoff_r;
  assign rdoff_inc = rdoff_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  assign status.is_pop   = (act_r == ACT_POP);
  assign status.out_free = !o_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r <= FRAME_BYTES_RST;
      realtime_r    <= 1'b0;
      lim_rt_r      <= LIMIT_RST;
      lim_def_r     <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_BYTES:    frame_bytes_r <= cfg_wdata;
        CFG_REALTIME_MODE:  realtime_r    <= cfg_wdata[0];
        CFG_LIMIT_REALTIME: lim_rt_r      <= cfg_wdata[LIMIT_W-1:0];
        CFG_LIMIT_DEFAULT:  lim_def_r     <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r    <= action_t'(in_tuser[1:0]);
      data_r   <= in_tdata;
      last_r   <= in_tlast;
      has_id_r <= in_tuser[2];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    rdoff_nxt     = rdoff_r;
    odd_byte_nxt  = odd_byte_r;
    odd_valid_nxt = odd_valid_r;
    held_nxt      = held_r;
    ckpt_nxt      = ckpt_r;
    idp_nxt       = idp_r;
    drop_acc_nxt  = drop_acc_r;
    o_byte_nxt    = o_byte_r;
    o_bv_nxt      = o_bv_r;
    o_last_nxt    = o_last_r;
    o_played_nxt  = o_played_r;
    o_drop_nxt    = o_drop_r;
    o_ovf_nxt     = o_ovf_r;
    o_count_nxt   = o_count_r;
    o_valid_nxt   = o_valid_r && !out_tready;
    bsel_nxt      = bsel_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wa        = ADDR_W'(tail_r) * ADDR_W'(WORDS_PER_SLOT) + ADDR_W'(fill_r[OFF_W-1:1]);
    ram_ra        = ADDR_W'(head_r) * ADDR_W'(WORDS_PER_SLOT) + ADDR_W'(off_cl[OFF_W-1:1]);
    ram_wd        = {data_r, odd_byte_r};

    if (cmd.latch) begin
      drop_acc_nxt = 1'b0;
    end

    if (cmd.retry && (act_r == ACT_PUSH) && held_r && cm.ok) begin
      head_nxt     = cm.head;
      tail_nxt     = cm.tail;
      count_nxt    = cm.count;
      rdoff_nxt    = cm.rdoff;
      fill_nxt     = '0;
      held_nxt     = 1'b0;
      drop_acc_nxt = cm.drop;
    end

    if (cmd.act) begin
      o_bv_nxt     = 1'b0;
      o_last_nxt   = 1'b0;
      o_played_nxt = 1'b0;
      o_ovf_nxt    = 1'b0;
      o_byte_nxt   = '0;
      o_drop_nxt   = drop_acc_r;
      case (act_r)
        ACT_PUSH: begin
          if (!odd_valid_r) begin
            if (!last_r) begin
              odd_byte_nxt  = data_r;
              odd_valid_nxt = 1'b1;
            end
          end else begin
            odd_valid_nxt = 1'b0;
            if (held_r) begin
              o_ovf_nxt = 1'b1;
            end else begin
              ram_we   = 1'b1;
              fill_nxt = fill_add;
              if (fill_add >= eff_f) begin
                held_nxt = 1'b1;
                if (cm.ok) begin
                  head_nxt   = cm.head;
                  tail_nxt   = cm.tail;
                  count_nxt  = cm.count;
                  rdoff_nxt  = cm.rdoff;
                  fill_nxt   = '0;
                  held_nxt   = 1'b0;
                  o_drop_nxt = drop_acc_r || cm.drop;
                end
              end
            end
          end
        end
        ACT_POP: begin
          if (count_r != '0) begin
            ram_re    = 1'b1;
            bsel_nxt  = off_cl[0];
            o_bv_nxt  = 1'b1;
            rdoff_nxt = rdoff_inc;
            if (rdoff_inc >= eff_f) begin
              o_last_nxt = 1'b1;
              rdoff_nxt  = '0;
              head_nxt   = slot_inc(head_r);
              count_nxt  = count_dec;
              if (ckpt_r && (count_dec == '0) && idp_r) begin
                o_played_nxt = 1'b1;
                ckpt_nxt     = 1'b0;
                idp_nxt      = 1'b0;
              end
            end
          end
        end
        ACT_CLEAR: begin
          head_nxt      = '0;
          tail_nxt      = '0;
          count_nxt     = '0;
          fill_nxt      = '0;
          rdoff_nxt     = '0;
          odd_valid_nxt = 1'b0;
          held_nxt      = 1'b0;
          ckpt_nxt      = 1'b0;
          idp_nxt       = 1'b0;
        end
        ACT_CKPT: begin
          ckpt_nxt = 1'b1;
          if (has_id_r) begin
            idp_nxt = 1'b1;
          end
        end
        default: ;
      endcase
      o_count_nxt = count_nxt;
      if (act_r != ACT_POP) begin
        o_valid_nxt = 1'b1;
      end
    end

    if (cmd.rd_done) begin
      o_valid_nxt = 1'b1;
      if (o_bv_r) begin
        o_byte_nxt = bsel_r ? rd_data_r[15:8] : rd_data_r[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram[ram_wa] <= ram_wd;
    end
    if (ram_re) begin
      rd_data_r <= ram[ram_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      rdoff_r     <= '0;
      odd_byte_r  <= '0;
      odd_valid_r <= 1'b0;
      held_r      <= 1'b0;
      ckpt_r      <= 1'b0;
      idp_r       <= 1'b0;
      drop_acc_r  <= 1'b0;
      o_valid_r   <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      rdoff_r     <= rdoff_nxt;
      odd_byte_r  <= odd_byte_nxt;
      odd_valid_r <= odd_valid_nxt;
      held_r      <= held_nxt;
      ckpt_r      <= ckpt_nxt;
      idp_r       <= idp_nxt;
      drop_acc_r  <= drop_acc_nxt;
      o_valid_r   <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bsel_r     <= bsel_nxt;
    o_byte_r   <= o_byte_nxt;
    o_bv_r     <= o_bv_nxt;
    o_last_r   <= o_last_nxt;
    o_played_r <= o_played_nxt;
    o_drop_r   <= o_drop_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_count_r  <= o_count_nxt;
  end

  assign out_tvalid = o_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_bv_r;
  assign out_tdata  = {6'd0, o_count_r, o_ovf_r, o_drop_r, o_played_r, o_byte_r};

endmodule

// ===== dv/audio_frame_packer_queue_core_test.sv =====
module audio_frame_packer_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import afpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] pcm_byte;
    logic       byte_ok;
    logic       frame_end;
    logic       played;
    logic       dropped;
    logic       ovf;
    logic [6:0] queued;
  } step_result_t;

  class packer_queue_tracker;
    bit [7:0]     pcm [QUEUE_FRAMES * MAX_FRAME_BYTES];
    int unsigned  head, tail, count, fill, rdoff;
    bit [7:0]     odd_data;
    bit           odd_ok, held, ckpt_wait, id_seen;
    bit [10:0]    frame_reg;
    bit           rt_mode;
    bit [6:0]     lim_rt, lim_def;
    step_result_t pending_results[$];
    int unsigned  errors;

    function new();
      frame_reg = FRAME_BYTES_RST;
      lim_rt    = LIMIT_RST;
      lim_def   = LIMIT_RST;
    endfunction

    function int unsigned frame_len();
      int unsigned f;
      f = frame_reg;
      if (f < 2) f = 2;
      if (f > (MAX_FRAME_BYTES / 2) * 2) f = (MAX_FRAME_BYTES / 2) * 2;
      return f & ~32'd1;
    endfunction

    function int unsigned cap(bit [6:0] l);
      int unsigned v;
      v = l;
      if (v < 1) v = 1;
      if (v > QUEUE_FRAMES - 1) v = QUEUE_FRAMES - 1;
      return v;
    endfunction

    // Returns 1 when the oldest frame was discarded to make room.
    function bit enqueue_frame();
      bit lost;
      lost = 1'b0;
      if (rt_mode) begin
        if (count >= cap(lim_rt) && count > 0) begin
          head  = (head + 1) % QUEUE_FRAMES;
          count = count - 1;
          rdoff = 0;
          lost  = 1'b1;
        end
      end else if (count >= cap(lim_def)) begin
        return 1'b0;
      end
      count = count + 1;
      tail  = (tail + 1) % QUEUE_FRAMES;
      fill  = 0;
      held  = 1'b0;
      return lost;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRAME_BYTES:    frame_reg = val;
        CFG_REALTIME_MODE:  rt_mode   = val[0];
        CFG_LIMIT_REALTIME: lim_rt    = val[6:0];
        CFG_LIMIT_DEFAULT:  lim_def   = val[6:0];
        default: ;
      endcase
    endfunction

    function void take_beat(action_t act, bit [7:0] d, bit l, bit sid);
      step_result_t r;
      int unsigned  base;
      int unsigned  off;
      r = '0;
      case (act)
        ACT_PUSH: begin
          if (held) r.dropped = r.dropped | enqueue_frame();
          if (!odd_ok) begin
            if (!l) begin
              odd_data = d;
              odd_ok   = 1'b1;
            end
          end else begin
            odd_ok = 1'b0;
            if (held) begin
              r.ovf = 1'b1;
            end else begin
              base = tail * MAX_FRAME_BYTES;
              if (fill + 1 < MAX_FRAME_BYTES) begin
                pcm[base + fill]     = odd_data;
                pcm[base + fill + 1] = d;
              end
              fill = fill + 2;
              if (fill >= frame_len()) begin
                held      = 1'b1;
                r.dropped = r.dropped | enqueue_frame();
              end
            end
          end
        end
        ACT_POP: begin
          if (count > 0) begin
            off         = (rdoff >= MAX_FRAME_BYTES) ? MAX_FRAME_BYTES - 1 : rdoff;
            r.pcm_byte  = pcm[head * MAX_FRAME_BYTES + off];
            r.byte_ok   = 1'b1;
            rdoff       = rdoff + 1;
            if (rdoff >= frame_len()) begin
              r.frame_end = 1'b1;
              rdoff       = 0;
              head        = (head + 1) % QUEUE_FRAMES;
              count       = count - 1;
              if (ckpt_wait && count == 0 && id_seen) begin
                r.played  = 1'b1;
                ckpt_wait = 1'b0;
                id_seen   = 1'b0;
              end
            end
          end
        end
        ACT_CLEAR: begin
          head      = 0;
          tail      = 0;
          count     = 0;
          fill      = 0;
          rdoff     = 0;
          odd_ok    = 1'b0;
          held      = 1'b0;
          ckpt_wait = 1'b0;
          id_seen   = 1'b0;
        end
        default: begin
          ckpt_wait = 1'b1;
          if (sid) id_seen = 1'b1;
        end
      endcase
      r.queued = 7'(count);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
      end
    endfunction

    function void match_result(bit [OUT_TDATA_W-1:0] td, bit tl, bit tu);
      step_result_t w;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, td);
        end
        return;
      end
      w = pending_results.pop_front();
      check_field("out_byte", w.pcm_byte, td[7:0]);
      check_field("played_stream", w.played, td[8]);
      check_field("dropped_oldest", w.dropped, td[9]);
      check_field("overflow", w.ovf, td[10]);
      check_field("frames_queued", w.queued, td[17:11]);
      check_field("tdata padding", 0, td[OUT_TDATA_W-1:18]);
      check_field("frame_last", w.frame_end, tl);
      check_field("byte_valid", w.byte_ok, tu);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  packer_queue_tracker tracker;
  int unsigned         send_idle;
  int unsigned         recv_idle;
  int unsigned         cycles = 0;

  audio_frame_packer_queue_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_result(out_tdata, out_tlast, out_tuser);
    end
  end

  task automatic send_beat(action_t act, bit [7:0] d, bit l, bit sid);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    in_tuser  <= {sid, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_beat(act, d, l, sid);
    @(negedge clk);
  endtask

  // Hold the sender until every result is back, then let the core go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(bit [10:0] fb, bit rt, bit [6:0] lrt, bit [6:0] ldef);
    logic [CFG_ADDR_W-1:0] idx [4];
    bit [CFG_DATA_W-1:0]   vals [4];
    idx  = '{CFG_FRAME_BYTES, CFG_REALTIME_MODE, CFG_LIMIT_REALTIME, CFG_LIMIT_DEFAULT};
    vals = '{fb, CFG_DATA_W'(rt), CFG_DATA_W'(lrt), CFG_DATA_W'(ldef)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      tracker.set_reg(idx[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(int unsigned n, int unsigned push_pct);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      len  = $urandom_range(1, 24);
      if (pick < push_pct) begin
        for (int unsigned k = 0; k < len; k++) begin
          send_beat(ACT_PUSH, 8'($urandom_range(255)),
                    (k == len - 1) || ($urandom_range(19) == 0), 1'($urandom_range(1)));
        end
        sent += len;
      end else if (pick < 94) begin
        for (int unsigned k = 0; k < len; k++) begin
          send_beat(ACT_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
        sent += len;
      end else if (pick < 99) begin
        send_beat(ACT_CKPT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  $urandom_range(3) != 0);
        sent++;
      end else begin
        send_beat(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic run_phase(bit wipe, bit [10:0] fb, bit rt, bit [6:0] lrt, bit [6:0] ldef,
                           int unsigned n, int unsigned push_pct);
    if (wipe) send_beat(ACT_CLEAR, 8'h00, 1'b0, 1'b0);
    settle();
    configure(fb, rt, lrt, ldef);
    run_traffic(n, push_pct);
  endtask

  initial begin
    tracker    = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    in_tuser   = '0;
    out_tready = 1'b0;
    send_idle  = 37;
    recv_idle  = 76;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    configure(11'd4, 1'b0, 7'd0, 7'd1);
    send_beat(ACT_POP, 8'h00, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h00, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'hFF, 1'b1, 1'b1);
    send_beat(ACT_PUSH, 8'hA5, 1'b1, 1'b0);
    send_beat(ACT_PUSH, 8'h5A, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h3C, 1'b1, 1'b0);
    send_beat(ACT_PUSH, 8'h11, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h22, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h33, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h44, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h55, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h66, 1'b1, 1'b0);
    send_beat(ACT_CKPT, 8'h00, 1'b0, 1'b0);
    send_beat(ACT_CKPT, 8'h00, 1'b0, 1'b1);
    send_beat(ACT_POP, 8'h00, 1'b0, 1'b0);
    send_beat(ACT_POP, 8'h00, 1'b0, 1'b0);
    settle();
    configure(11'd4, 1'b1, 7'd0, 7'd1);
    send_beat(ACT_PUSH, 8'h77, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h88, 1'b0, 1'b0);
    repeat (5) send_beat(ACT_POP, 8'h00, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'h99, 1'b0, 1'b0);
    send_beat(ACT_PUSH, 8'hAA, 1'b1, 1'b0);
    send_beat(ACT_CLEAR, 8'h00, 1'b0, 1'b0);

    run_phase(1'b0, 11'd6, 1'b0, 7'd64, 7'd2, 180, 55);
    run_phase(1'b0, 11'd6, 1'b1, 7'd2, 7'd64, 180, 55);
    send_idle = 76;
    recv_idle = 37;
    run_phase(1'b1, 11'd2047, 1'b0, 7'd127, 7'd127, 50, 70);
    run_phase(1'b1, 11'd1, 1'b1, 7'd0, 7'd0, 150, 55);
    send_idle = 0;
    recv_idle = 0;
    run_phase(1'b1, 11'd2, 1'b0, 7'd127, 7'd127, 260, 80);
    run_phase(1'b1, 11'd2, 1'b1, 7'd64, 7'd64, 230, 85);
    settle();

    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
